/* design/rpc_pkg.sv */
`default_nettype none

package rpc_pkg;

  // Deepest folder level tracked; the depth counter saturates here
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  typedef logic [7:0]         path_byte_t;
  typedef logic [1:0]         verdict_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  // Character codes
  localparam path_byte_t CH_NUL   = 8'h00;
  localparam path_byte_t CH_TAB   = 8'h09;
  localparam path_byte_t CH_CR    = 8'h0D;
  localparam path_byte_t CH_SPACE = 8'h20;
  localparam path_byte_t CH_DOT   = 8'h2E;
  localparam path_byte_t CH_SLASH = 8'h2F;
  localparam path_byte_t CH_COLON = 8'h3A;
  localparam path_byte_t CH_BSL   = 8'h5C;

  // Verdict codes
  localparam verdict_t VERDICT_OK       = 2'd0;
  localparam verdict_t VERDICT_BLANK    = 2'd1;
  localparam verdict_t VERDICT_ABSOLUTE = 2'd2;
  localparam verdict_t VERDICT_ESCAPE   = 2'd3;

  // Kind of the segment being read
  typedef enum logic [1:0] {
    SEG_EMPTY  = 2'd0,
    SEG_DOT    = 2'd1,
    SEG_DOTDOT = 2'd2,
    SEG_OTHER  = 2'd3
  } seg_kind_t;

  // Held input stage, as seen by the scanner
  typedef struct packed {
    logic       valid;
    path_byte_t path_byte;
  } stage_t;

endpackage

`default_nettype wire

/* design/rpc_if.sv */
`default_nettype none

interface rpc_in_if;
  logic                valid;
  logic                ready;
  rpc_pkg::path_byte_t path_byte;

  modport source (output valid, output path_byte, input ready);
  modport sink   (input valid, input path_byte, output ready);
endinterface

interface rpc_out_if;
  logic              valid;
  logic              ready;
  rpc_pkg::verdict_t verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

/* design/rpc_in_stage.sv */
`default_nettype none

module rpc_in_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  rpc_pkg::path_byte_t load_byte,
  input  wire                 advance,
  output rpc_pkg::stage_t     stage
);

  logic                valid_r, valid_nxt;
  rpc_pkg::path_byte_t byte_r;

  // Hold a request until the scanner takes it, refill on accept
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= load_byte;
    end
  end

  assign stage.valid     = valid_r;
  assign stage.path_byte = byte_r;

endmodule

`default_nettype wire

/* design/rpc_scan.sv */
`default_nettype none

module rpc_scan (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rpc_pkg::path_byte_t path_byte,
  input  wire                 advance,
  output logic                is_term,
  output rpc_pkg::verdict_t   verdict
);

  logic                at_start_r,  at_start_nxt;
  logic                nonblank_r,  nonblank_nxt;
  logic                absolute_r,  absolute_nxt;
  logic                escape_r,    escape_nxt;
  rpc_pkg::depth_t     depth_r,     depth_nxt;
  rpc_pkg::seg_kind_t  seg_r,       seg_nxt;

  rpc_pkg::path_byte_t b;
  logic                is_slash, is_dot, is_colon, is_blank;
  rpc_pkg::depth_t     depth_closed;
  logic                escape_closed;

  assign b        = path_byte;
  assign is_term  = (b == rpc_pkg::CH_NUL);
  assign is_slash = (b == rpc_pkg::CH_SLASH) || (b == rpc_pkg::CH_BSL);
  assign is_dot   = (b == rpc_pkg::CH_DOT);
  assign is_colon = (b == rpc_pkg::CH_COLON);
  assign is_blank = (b == rpc_pkg::CH_SPACE) ||
                    ((b >= rpc_pkg::CH_TAB) && (b <= rpc_pkg::CH_CR));

  // Close the current segment: climb on dot-dot, descend on a name
  always_comb begin
    depth_closed  = depth_r;
    escape_closed = escape_r;
    case (seg_r)
      rpc_pkg::SEG_DOTDOT: begin
        if (depth_r == '0) begin
          escape_closed = 1'b1;
        end else begin
          depth_closed = depth_r - rpc_pkg::DEPTH_W'(1);
        end
      end
      rpc_pkg::SEG_OTHER: begin
        if (depth_r < rpc_pkg::DEPTH_W'(rpc_pkg::MAX_DEPTH)) begin
          depth_closed = depth_r + rpc_pkg::DEPTH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Verdict for a terminator, by precedence
  always_comb begin
    if (!nonblank_r) begin
      verdict = rpc_pkg::VERDICT_BLANK;
    end else if (absolute_r) begin
      verdict = rpc_pkg::VERDICT_ABSOLUTE;
    end else if (escape_closed) begin
      verdict = rpc_pkg::VERDICT_ESCAPE;
    end else begin
      verdict = rpc_pkg::VERDICT_OK;
    end
  end

  // Advance the path state by one byte; a terminator clears it all
  always_comb begin
    at_start_nxt = at_start_r;
    nonblank_nxt = nonblank_r;
    absolute_nxt = absolute_r;
    escape_nxt   = escape_r;
    depth_nxt    = depth_r;
    seg_nxt      = seg_r;
    if (advance) begin
      if (is_term) begin
        at_start_nxt = 1'b1;
        nonblank_nxt = 1'b0;
        absolute_nxt = 1'b0;
        escape_nxt   = 1'b0;
        depth_nxt    = '0;
        seg_nxt      = rpc_pkg::SEG_EMPTY;
      end else begin
        at_start_nxt = 1'b0;
        nonblank_nxt = nonblank_r | ~is_blank;
        absolute_nxt = absolute_r | is_colon | (at_start_r & is_slash);
        if (is_slash) begin
          depth_nxt  = depth_closed;
          escape_nxt = escape_closed;
          seg_nxt    = rpc_pkg::SEG_EMPTY;
        end else if (is_dot) begin
          case (seg_r)
            rpc_pkg::SEG_EMPTY: seg_nxt = rpc_pkg::SEG_DOT;
            rpc_pkg::SEG_DOT:   seg_nxt = rpc_pkg::SEG_DOTDOT;
            default:            seg_nxt = rpc_pkg::SEG_OTHER;
          endcase
        end else begin
          seg_nxt = rpc_pkg::SEG_OTHER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      nonblank_r <= 1'b0;
      absolute_r <= 1'b0;
      escape_r   <= 1'b0;
      depth_r    <= '0;
      seg_r      <= rpc_pkg::SEG_EMPTY;
    end else begin
      at_start_r <= at_start_nxt;
      nonblank_r <= nonblank_nxt;
      absolute_r <= absolute_nxt;
      escape_r   <= escape_nxt;
      depth_r    <= depth_nxt;
      seg_r      <= seg_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/relative_path_checker.sv */
// A terminator passes the input stage register, then its verdict is held in the verdict
// register until taken; it waits longer only while an earlier verdict is not taken.
// Throughput: one path byte per cycle while no terminator is stalled; the held input byte
// and the verdict register let requests stream on while a verdict waits to be taken.
// Only a terminator waits on the result side; other bytes pass the scanner freely.
// Reset (rst_n low, synchronous) empties both registers and returns the scanner
// to the start of a path.
`default_nettype none

module relative_path_checker (
  input  wire         clk,
  input  wire         rst_n,
  rpc_in_if.sink      in_chan,
  rpc_out_if.source   out_chan
);

  rpc_pkg::stage_t   stage;
  logic              is_term;
  rpc_pkg::verdict_t verdict;
  logic              out_free;
  logic              advance;
  logic              load;

  logic              out_valid_r, out_valid_nxt;
  rpc_pkg::verdict_t verdict_r;

  // Let a byte through unless it is a terminator facing a full result register
  assign out_free       = ~out_valid_r | out_chan.ready;
  assign advance        = stage.valid & (~is_term | out_free);
  assign in_chan.ready  = ~stage.valid | advance;
  assign load           = in_chan.valid & in_chan.ready;

  rpc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_byte (in_chan.path_byte),
    .advance   (advance),
    .stage     (stage)
  );

  rpc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .path_byte (stage.path_byte),
    .advance   (advance),
    .is_term   (is_term),
    .verdict   (verdict)
  );

  // Hold the verdict until taken, load it when a terminator passes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && is_term) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_term) begin
      verdict_r <= verdict;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.verdict = verdict_r;

  // A verdict appears only after a terminator left the input stage
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && is_term))
    else $error("verdict raised without a terminator");

  // A terminator facing a stalled full result register blocks new requests
  a_term_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && is_term && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while a terminator is stuck");

  // A passed terminator leaves the result register full
  a_term_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_term) |=> out_valid_r)
    else $error("terminator passed but no verdict held");

endmodule

`default_nettype wire

/* sim/path_verdict_checker.sv */
`timescale 1ns / 1ps

module path_verdict_checker
  import rpc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  rpc_in_if           in_chan,
  rpc_out_if          out_chan,
  output int unsigned mismatches,
  output int unsigned verdicts_pending
);

  // Scanner state, updated once per accepted path byte
  logic        at_start;
  logic        nonblank;
  logic        absolute;
  logic        escaped;
  int unsigned depth;
  seg_kind_t   seg;

  // Verdicts owed by the block, oldest first
  verdict_t    verdicts_due[$];

  function automatic void clear_scan();
    at_start = 1'b1;
    nonblank = 1'b0;
    absolute = 1'b0;
    escaped  = 1'b0;
    depth    = 0;
    seg      = SEG_EMPTY;
  endfunction

  // Fold the finished segment into the depth; climbing from the top is sticky
  function automatic void end_segment();
    if (seg == SEG_DOTDOT) begin
      if (depth == 0) escaped = 1'b1;
      else depth--;
    end else if (seg == SEG_OTHER) begin
      if (depth < MAX_DEPTH) depth++;
    end
    seg = SEG_EMPTY;
  endfunction

  function automatic void predict_byte(input path_byte_t b);
    verdict_t v;
    if (b == CH_NUL) begin
      end_segment();
      if (!nonblank) v = VERDICT_BLANK;
      else if (absolute) v = VERDICT_ABSOLUTE;
      else if (escaped) v = VERDICT_ESCAPE;
      else v = VERDICT_OK;
      verdicts_due = {verdicts_due, v};
      clear_scan();
      return;
    end
    if (b != CH_SPACE && (b < CH_TAB || b > CH_CR)) nonblank = 1'b1;
    if (b == CH_COLON) absolute = 1'b1;
    if (at_start && (b == CH_SLASH || b == CH_BSL)) absolute = 1'b1;
    at_start = 1'b0;
    if (b == CH_SLASH || b == CH_BSL) begin
      end_segment();
    end else if (b == CH_DOT) begin
      case (seg)
        SEG_EMPTY: seg = SEG_DOT;
        SEG_DOT:   seg = SEG_DOTDOT;
        default:   seg = SEG_OTHER;
      endcase
    end else begin
      seg = SEG_OTHER;
    end
  endfunction

  // Check the verdict first, then predict from the request of this edge
  always @(posedge clk) begin
    verdict_t due;
    if (!rst_n) begin
      clear_scan();
      verdicts_due.delete();
      mismatches = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (verdicts_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected verdict, expected none, actual %0d",
                   $time, out_chan.verdict);
        end else begin
          due = verdicts_due.pop_front();
          if (out_chan.verdict !== due) begin
            mismatches++;
            $display("%0t: verdict mismatch, expected %0d, actual %0d",
                     $time, due, out_chan.verdict);
          end
        end
      end
      if (in_chan.valid && in_chan.ready) predict_byte(in_chan.path_byte);
    end
    verdicts_pending <= verdicts_due.size();
  end

endmodule

/* sim/tb_relative_path_checker.sv */
`timescale 1ns / 1ps

module tb_relative_path_checker;
  import rpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_BUDGET = 105;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches;
  int unsigned verdicts_pending;

  rpc_in_if  in_chan ();
  rpc_out_if out_chan ();

  relative_path_checker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  path_verdict_checker verdict_mon (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_chan          (in_chan),
    .out_chan         (out_chan),
    .mismatches       (mismatches),
    .verdicts_pending (verdicts_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random at the rate of the current phase
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold one request until accepted, with random idle cycles ahead of it
  task automatic send_byte(input path_byte_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.path_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_path(input path_byte_t bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i]);
    send_byte(CH_NUL);
  endtask

  // Drop valid and wait until every verdict owed has been taken
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
  endtask

  function automatic path_byte_t name_char();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return CH_COLON;
    if (r <= 2) return CH_DOT;
    if (r <= 5) return path_byte_t'($urandom_range(1, 255));
    return path_byte_t'("a" + $urandom_range(25));
  endfunction

  // Mostly well-formed paths, some blank ones and some raw noise
  task automatic make_random_path(output path_byte_t q[$]);
    int unsigned pick;
    int unsigned n_seg;
    path_byte_t  sep;
    q = {};
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(4)) begin
        if ($urandom_range(5) == 0) q = {q, CH_SPACE};
        else q = {q, path_byte_t'($urandom_range(CH_TAB, CH_CR))};
      end
    end else if (pick < 18) begin
      repeat ($urandom_range(1, 8)) q = {q, path_byte_t'($urandom_range(1, 255))};
    end else begin
      if ($urandom_range(9) == 0) q = {q, ($urandom_range(1) ? CH_SLASH : CH_BSL)};
      n_seg = $urandom_range(1, 6);
      for (int s = 0; s < n_seg; s++) begin
        sep = $urandom_range(1) ? CH_SLASH : CH_BSL;
        if (s != 0) q = {q, sep};
        case ($urandom_range(9))
          0, 1: begin
            q = {q, CH_DOT, CH_DOT};
          end
          2: q = {q, CH_DOT};
          3: ;
          default: repeat ($urandom_range(1, 3)) q = {q, name_char()};
        endcase
      end
      if ($urandom_range(9) == 0) q = {q, CH_SLASH};
    end
  endtask

  initial begin
    path_byte_t  path_q[$];
    int unsigned bytes_sent;
    in_chan.valid     <= 1'b0;
    in_chan.path_byte <= CH_NUL;
    bytes_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty, blank, absolute, colon, precedence, sticky escape, high bytes
    send_byte(CH_NUL);
    send_path('{CH_TAB, CH_CR});
    send_path('{CH_SLASH});
    send_path('{CH_BSL, CH_DOT, CH_DOT});
    send_path('{CH_COLON});
    send_path('{CH_DOT, CH_DOT, CH_BSL, "a"});
    send_path('{"a", CH_SLASH, CH_DOT, CH_SLASH, CH_DOT, CH_DOT});
    send_path('{CH_DOT, CH_DOT, CH_DOT, CH_BSL, 8'h01, 8'hFF});

    // Random phases with different idle and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 50; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 50; end
        default: begin
          in_idle_pct   = 7;
          out_stall_pct = 7;
          // Deep path: depth saturates, so climbing back all the way escapes
          path_q = {};
          repeat (MAX_DEPTH + 1) begin
            path_q = {path_q, path_byte_t'("d"), CH_SLASH};
          end
          repeat (MAX_DEPTH + 1) begin
            path_q = {path_q, CH_DOT, CH_DOT, CH_BSL};
          end
          send_path(path_q);
        end
      endcase
      while (bytes_sent < PHASE_BUDGET * (ph + 1)) begin
        make_random_path(path_q);
        send_path(path_q);
        bytes_sent += path_q.size() + 1;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
